>>> rtl/core/sbp_pkg.sv
// Package for the soil bottom percolation pipeline: stage map, item record and root table.
`default_nettype none
package sbp_pkg;

	localparam int IN_W  = 320;
	localparam int OUT_W = 120;

	// Stage map of the pipeline.
	localparam int ST_KEFF  = 1;
	localparam int ST_DIV0  = 2;
	localparam int DIV_LEN  = 50;
	localparam int SE_LEN   = 24;
	localparam int RISE_LEN = 32;
	localparam int LOG_NORM = 24;
	localparam int LOG_LEN  = 24;
	localparam int ST_P1    = ST_DIV0 + DIV_LEN;
	localparam int ST_P2    = ST_P1 + 1;
	localparam int ST_P3    = ST_P2 + 1;
	localparam int ST_POW0  = ST_P3 + 1;
	localparam int POW_LEN  = 32;
	localparam int ST_SHIFT = ST_POW0 + POW_LEN;
	localparam int ST_FLUX  = ST_SHIFT + 1;
	localparam int ST_STORE = ST_FLUX + 1;
	localparam int ST_PERC  = ST_STORE + 1;
	localparam int ST_TDIV0 = ST_PERC + 1;
	localparam int TDIV_LEN = 25;
	localparam int ST_FINAL = ST_TDIV0 + TDIV_LEN;
	localparam int NST      = ST_FINAL + 1;

	localparam logic [32:0] FRONT_GAP = 33'd16777;
	localparam logic [31:0] KSAT_ONE  = 32'd16777216;

	typedef enum logic [1:0] {
		CFG_TWO_LAYER   = 2'd0,
		CFG_GW_FLOW     = 2'd1,
		CFG_GW_MARGIN   = 2'd2,
		CFG_KSAT_FACTOR = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [23:0] cell_idx;
		logic [31:0] front;
		logic [24:0] thr;
		logic [24:0] theta;
		logic [24:0] fc;
		logic [24:0] dth;
		logic [31:0] ks;
		logic [31:0] keff;
		logic [31:0] dl;
		logic [31:0] lam;
		logic [24:0] se_den;
		logic [24:0] fc_den;
		logic        pass;
		logic        front_low;
		logic        se_sat;
		logic        pore_gt_fc;
		logic        rise_big;
		logic [24:0] se_rem;
		logic [23:0] se_q;
		logic [31:0] e_rem;
		logic [49:0] e_q;
		logic [24:0] r_rem;
		logic [31:0] r_num;
		logic [31:0] r_q;
		logic [24:0] lm;
		logic [4:0]  lk;
		logic [23:0] lf;
		logic [28:0] lval;
		logic [49:0] e_v;
		logic [53:0] p_lo;
		logic [53:0] p_hi;
		logic        pw_zero;
		logic [31:0] frac;
		logic [4:0]  pint;
		logic [32:0] acc;
		logic [32:0] pw;
		logic [31:0] flux;
		logic [56:0] m;
		logic [31:0] perc;
		logic [31:0] t_rem;
		logic [24:0] t_num;
		logic [24:0] t_q;
		logic [31:0] o_perc;
		logic [24:0] o_theta;
		logic [31:0] o_front;
		logic        o_upd;
	} st_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] xin);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bv;
		x   = xin;
		res = 64'd0;
		bv  = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bv > x) bv = bv >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bv != 64'd0) begin
				if (x >= res + bv) begin
					x   = x - (res + bv);
					res = (res >> 1) + bv;
				end else begin
					res = res >> 1;
				end
				bv = bv >> 2;
			end
		end
		return res;
	endfunction

	// Weight of fraction bit idx of the exponent: 2^-(2^(idx-32)) in Q32.
	function automatic logic [31:0] root_q32(input int idx);
		logic [63:0] r;
		r = 64'h8000_0000;
		for (int n = 31; n >= 0; n--) begin
			if (n >= idx) r = isqrt64(r << 32);
		end
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/soil_bottom_percolation.sv
// Top level: pipelined bottom percolation of one soil cell per item.
// Throughput: one item per cycle while the skid stage is empty; the depth comes
// mainly from the 50-step divider for the exponent, the 32 multiply stages of the
// fractional power and the divider for the new moisture.
// A two-entry output register and skid stage hold results while tready is low.
// Reset clears all valid bits and loads the configuration registers with their reset values.
`default_nettype none
module soil_bottom_percolation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// cell_index, wetting_front, depth_top_layer, depth_bottom_layer, porosity,
	// residual_moisture, moisture_now, field_capacity, ksat, pore_index, gw_height
	input  wire logic [319:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// cell_index_out, percolation, moisture_new, wetting_front_new, updated
	output logic [119:0]     m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int NST = sbp_pkg::NST;

	logic        two_layer_q;
	logic        gw_flow_q;
	logic [31:0] gw_margin_q;
	logic [31:0] ksat_factor_q;

	sbp_pkg::st_t pipe [NST];
	sbp_pkg::st_t nxt  [NST];
	logic [NST-1:0] vld_q;

	logic en;
	logic out_v_q, skid_v_q;
	logic [119:0] out_d_q, skid_d_q, exit_d;
	logic take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_layer_q   <= 1'b0;
			gw_flow_q     <= 1'b0;
			gw_margin_q   <= 32'd0;
			ksat_factor_q <= sbp_pkg::KSAT_ONE;
		end else if (cfg_valid) begin
			case (sbp_pkg::cfg_idx_t'(cfg_index))
				sbp_pkg::CFG_TWO_LAYER:   two_layer_q   <= cfg_data[0];
				sbp_pkg::CFG_GW_FLOW:     gw_flow_q     <= cfg_data[0];
				sbp_pkg::CFG_GW_MARGIN:   gw_margin_q   <= cfg_data;
				sbp_pkg::CFG_KSAT_FACTOR: ksat_factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 0: decode the item, pick the bottom and the paths, prime the Se divider.
	always_comb begin
		logic [31:0] front, d1, d2, ks, lam, gw, bottom, top;
		logic [24:0] pore, thr, theta, fc;
		logic        blocked, pore_gt_thr;
		sbp_pkg::st_t n;
		front  = s_axis_tdata[55:24];
		d1     = s_axis_tdata[87:56];
		d2     = s_axis_tdata[119:88];
		pore   = s_axis_tdata[144:120];
		thr    = s_axis_tdata[169:145];
		theta  = s_axis_tdata[194:170];
		fc     = s_axis_tdata[219:195];
		ks     = s_axis_tdata[251:220];
		lam    = s_axis_tdata[283:252];
		gw     = s_axis_tdata[315:284];
		n      = '0;
		bottom = two_layer_q ? d2 : d1;
		blocked = gw_flow_q &&
			(({1'b0, gw} + {1'b0, gw_margin_q}) > {1'b0, bottom});
		n.cell_idx  = s_axis_tdata[23:0];
		n.front     = front;
		n.thr       = thr;
		n.theta     = theta;
		n.fc        = fc;
		n.ks        = ks;
		n.pass      = blocked || (theta <= thr);
		n.front_low = ({1'b0, front} + sbp_pkg::FRONT_GAP) < {1'b0, bottom};
		top         = (two_layer_q && (d1 > front)) ? d1 : front;
		n.dl        = (bottom > top) ? bottom - top : 32'd0;
		n.dth       = theta - thr;
		pore_gt_thr = pore > thr;
		n.se_den    = pore - thr;
		n.se_sat    = !pore_gt_thr || (n.dth >= n.se_den);
		n.se_rem    = n.se_sat ? 25'd0 : n.dth;
		n.lam       = (lam == 32'd0) ? 32'd1 : lam;
		n.pore_gt_fc = pore > fc;
		n.fc_den    = pore - fc;
		nxt[0]      = n;
	end

	for (genvar g = 1; g < NST; g++) begin : g_stage
		if (g == sbp_pkg::ST_KEFF) begin : g_keff
			always_comb begin
				logic [63:0] prod;
				sbp_pkg::st_t n;
				n    = pipe[g-1];
				prod = ksat_factor_q * n.ks;
				n.keff = (|prod[63:56]) ? 32'hFFFF_FFFF : prod[55:24];
				// A rise of 2^32 or more clears any front, so its divider needs 32 bits.
				n.rise_big = !n.pore_gt_fc || ({1'b0, n.keff} >= {n.fc_den, 8'd0});
				n.r_rem = n.rise_big ? 25'd0 : {1'b0, n.keff[31:8]};
				n.r_num = {n.keff[7:0], 24'd0};
				nxt[g] = n;
			end
		end else if (g >= sbp_pkg::ST_DIV0 && g < sbp_pkg::ST_P1) begin : g_div
			localparam int J = g - sbp_pkg::ST_DIV0;
			always_comb begin
				logic [32:0] sh_e;
				logic [25:0] sh_s, sh_r;
				logic [49:0] sq;
				logic [25:0] t;
				logic [24:0] mm;
				logic [4:0]  k;
				sbp_pkg::st_t n;
				n    = pipe[g-1];
				sh_s = '0;
				sh_r = '0;
				sq   = '0;
				t    = '0;
				mm   = '0;
				k    = '0;
				sh_e = {n.e_rem, (J == 0) ? 1'b1 : 1'b0};
				if (sh_e >= {1'b0, n.lam}) begin
					n.e_rem = 32'(sh_e - {1'b0, n.lam});
					n.e_q   = {n.e_q[48:0], 1'b1};
				end else begin
					n.e_rem = sh_e[31:0];
					n.e_q   = {n.e_q[48:0], 1'b0};
				end
				if (J < sbp_pkg::SE_LEN) begin
					sh_s = {n.se_rem, 1'b0};
					if (sh_s >= {1'b0, n.se_den}) begin
						n.se_rem = 25'(sh_s - {1'b0, n.se_den});
						n.se_q   = {n.se_q[22:0], 1'b1};
					end else begin
						n.se_rem = sh_s[24:0];
						n.se_q   = {n.se_q[22:0], 1'b0};
					end
				end
				if (J < sbp_pkg::RISE_LEN) begin
					sh_r    = {n.r_rem, n.r_num[31]};
					n.r_num = {n.r_num[30:0], 1'b0};
					if (sh_r >= {1'b0, n.fc_den}) begin
						n.r_rem = 25'(sh_r - {1'b0, n.fc_den});
						n.r_q   = {n.r_q[30:0], 1'b1};
					end else begin
						n.r_rem = sh_r[24:0];
						n.r_q   = {n.r_q[30:0], 1'b0};
					end
				end
				if (J == sbp_pkg::LOG_NORM) begin
					// Shift Se up until its top bit reaches weight one.
					for (int i = 0; i < 24; i++) begin
						if (n.se_q[i]) k = 5'(24 - i);
					end
					mm   = 25'({1'b0, n.se_q} << k);
					n.lm = mm;
					n.lk = k;
					n.lf = 24'd0;
				end
				if (J > sbp_pkg::LOG_NORM && J <= sbp_pkg::LOG_NORM + sbp_pkg::LOG_LEN) begin
					sq   = n.lm * n.lm;
					t    = sq[49:24];
					n.lf = {n.lf[22:0], t[25]};
					n.lm = t[25] ? t[25:1] : t[24:0];
				end
				if (J == sbp_pkg::DIV_LEN - 1) begin
					n.lval = {n.lk, 24'd0} - {5'd0, n.lf};
				end
				nxt[g] = n;
			end
		end else if (g == sbp_pkg::ST_P1) begin : g_p1
			always_comb begin
				sbp_pkg::st_t n;
				n      = pipe[g-1];
				n.e_v  = 50'd50331648 + n.e_q;
				n.p_lo = n.e_v[24:0] * n.lval;
				nxt[g] = n;
			end
		end else if (g == sbp_pkg::ST_P2) begin : g_p2
			always_comb begin
				sbp_pkg::st_t n;
				n      = pipe[g-1];
				n.p_hi = n.e_v[49:25] * n.lval;
				nxt[g] = n;
			end
		end else if (g == sbp_pkg::ST_P3) begin : g_p3
			always_comb begin
				logic [78:0] ptot;
				sbp_pkg::st_t n;
				n         = pipe[g-1];
				ptot      = {n.p_hi, 25'd0} + {25'd0, n.p_lo};
				// Past 64 bits or an integer part of 32 and more the power is zero.
				n.pw_zero = |ptot[78:53];
				n.pint    = ptot[52:48];
				n.frac    = ptot[47:16];
				n.acc     = 33'h1_0000_0000;
				nxt[g]    = n;
			end
		end else if (g >= sbp_pkg::ST_POW0 && g < sbp_pkg::ST_SHIFT) begin : g_pow
			localparam int BI = 31 - (g - sbp_pkg::ST_POW0);
			localparam logic [31:0] RV = sbp_pkg::root_q32(BI);
			always_comb begin
				logic [63:0] prod;
				sbp_pkg::st_t n;
				n    = pipe[g-1];
				prod = n.acc[31:0] * RV;
				if (n.frac[BI]) begin
					n.acc = n.acc[32] ? {1'b0, RV} : {1'b0, prod[63:32]};
				end
				nxt[g] = n;
			end
		end else if (g == sbp_pkg::ST_SHIFT) begin : g_shift
			always_comb begin
				sbp_pkg::st_t n;
				n    = pipe[g-1];
				n.pw = n.acc >> n.pint;
				if (n.se_sat) n.pw = 33'h1_0000_0000;
				else if (n.se_q == 24'd0 || n.pw_zero) n.pw = 33'd0;
				nxt[g] = n;
			end
		end else if (g == sbp_pkg::ST_FLUX) begin : g_flux
			always_comb begin
				logic [63:0] prod;
				sbp_pkg::st_t n;
				n      = pipe[g-1];
				prod   = n.keff * n.pw[31:0];
				n.flux = n.pw[32] ? n.keff : prod[63:32];
				nxt[g] = n;
			end
		end else if (g == sbp_pkg::ST_STORE) begin : g_store
			always_comb begin
				sbp_pkg::st_t n;
				n      = pipe[g-1];
				n.m    = n.dl * n.dth;
				nxt[g] = n;
			end
		end else if (g == sbp_pkg::ST_PERC) begin : g_perc
			always_comb begin
				logic [32:0] cap;
				logic [56:0] tnum;
				sbp_pkg::st_t n;
				n       = pipe[g-1];
				cap     = n.m[56:24];
				n.perc  = ({1'b0, n.flux} < cap) ? n.flux : cap[31:0];
				tnum    = n.m - {1'b0, n.perc, 24'd0};
				// The stored water never exceeds dl times the moisture, so the top bits fit.
				n.t_rem = tnum[56:25];
				n.t_num = tnum[24:0];
				n.t_q   = 25'd0;
				nxt[g]  = n;
			end
		end else if (g >= sbp_pkg::ST_TDIV0 && g < sbp_pkg::ST_FINAL) begin : g_tdiv
			always_comb begin
				logic [32:0] sh;
				sbp_pkg::st_t n;
				n       = pipe[g-1];
				sh      = {n.t_rem, n.t_num[24]};
				n.t_num = {n.t_num[23:0], 1'b0};
				if (sh >= {1'b0, n.dl}) begin
					n.t_rem = 32'(sh - {1'b0, n.dl});
					n.t_q   = {n.t_q[23:0], 1'b1};
				end else begin
					n.t_rem = sh[31:0];
					n.t_q   = {n.t_q[23:0], 1'b0};
				end
				nxt[g] = n;
			end
		end else begin : g_final
			always_comb begin
				sbp_pkg::st_t n;
				n         = pipe[g-1];
				n.o_perc  = 32'd0;
				n.o_theta = n.theta;
				n.o_front = n.front;
				n.o_upd   = 1'b0;
				if (!n.pass) begin
					n.o_upd = 1'b1;
					if (n.front_low) begin
						if (n.dl != 32'd0) begin
							n.o_perc  = n.perc;
							n.o_theta = n.thr + n.t_q;
						end
					end else begin
						n.o_theta = n.fc;
						n.o_perc  = n.keff;
						if (n.keff != 32'd0) begin
							if (n.rise_big || n.r_q >= n.front) n.o_front = 32'd0;
							else n.o_front = n.front - n.r_q;
						end
					end
				end
				nxt[g] = n;
			end
		end
	end

	assign en            = !skid_v_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NST; i++) pipe[i] <= nxt[i];
		end
	end

	assign exit_d = {6'd0, pipe[NST-1].o_upd, pipe[NST-1].o_front, pipe[NST-1].o_theta,
		pipe[NST-1].o_perc, pipe[NST-1].cell_idx};
	assign take = out_v_q && m_axis_tready;

	// The skid stage only fills when a result leaves the pipeline into a full output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) skid_v_q <= 1'b0;
		end else if (vld_q[NST-1]) begin
			if (!out_v_q || take) out_v_q <= 1'b1;
			else skid_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) out_d_q <= skid_d_q;
		end else if (vld_q[NST-1]) begin
			if (!out_v_q || take) out_d_q <= exit_d;
			else skid_d_q <= exit_d;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_d_q;

endmodule
`default_nettype wire

>>> sim/soil_bottom_percolation_tb.sv
// Self-checking testbench for the soil bottom percolation pipeline.
module soil_bottom_percolation_tb;

	typedef struct {
		logic [23:0] cell_index;
		logic [31:0] wetting_front;
		logic [31:0] depth_top_layer;
		logic [31:0] depth_bottom_layer;
		logic [24:0] porosity;
		logic [24:0] residual_moisture;
		logic [24:0] moisture_now;
		logic [24:0] field_capacity;
		logic [31:0] ksat;
		logic [31:0] pore_index;
		logic [31:0] gw_height;
	} cell_t;

	typedef struct {
		logic [23:0] cell_index_out;
		logic [31:0] percolation;
		logic [24:0] moisture_new;
		logic [31:0] wetting_front_new;
		logic        updated;
	} perc_t;

	localparam logic [63:0] ONE = 64'd1 << 24;
	localparam int LATENCY = 117;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [319:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [119:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = sbp_pkg::CFG_TWO_LAYER;
	logic [31:0] cfg_data = '0;

	// Shadow copy of the configuration registers.
	logic        sh_two_layer = 1'b0;
	logic        sh_gw_flow = 1'b0;
	logic [31:0] sh_gw_margin = '0;
	logic [31:0] sh_ksat_factor = sbp_pkg::KSAT_ONE;

	perc_t pending_perc[$];
	int errors = 0;
	int cycles = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_cnt = 0;
	int stall_phase = 0;
	int burst_left = 0;

	soil_bottom_percolation u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] root;
		logic [63:0] trial;
		root = 64'd0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x) root = trial;
		end
		return root;
	endfunction

	// -log2 of a saturation strictly between zero and one, Q24.
	function automatic logic [63:0] neg_log2_q24(input logic [63:0] sat);
		logic [63:0] m;
		logic [63:0] k;
		logic [63:0] f;
		m = sat;
		k = 0;
		f = 0;
		while (m < ONE) begin
			m = m << 1;
			k++;
		end
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 24;
			f = f << 1;
			if (m >= (ONE << 1)) begin
				m = m >> 1;
				f = f | 1;
			end
		end
		return (k << 24) - f;
	endfunction

	function automatic logic [63:0] sat_power_q32(input logic [63:0] sat, input logic [63:0] ex);
		logic [63:0] l;
		logic [63:0] p;
		logic [63:0] acc;
		logic [63:0] r;
		logic [31:0] frac;
		if (sat == 0) return 64'd0;
		if (sat >= ONE) return 64'd1 << 32;
		l = neg_log2_q24(sat);
		if (ex > 64'hFFFF_FFFF_FFFF_FFFF / l) return 64'd0;
		p = ex * l;
		if ((p >> 48) >= 32) return 64'd0;
		frac = p[47:16];
		acc = 64'd1 << 32;
		r = 64'd1 << 31;
		for (int i = 31; i >= 0; i--) begin
			r = int_sqrt(r << 32);
			if (frac[i]) acc = (acc * r) >> 32;
		end
		return acc >> (p >> 48);
	endfunction

	function automatic perc_t predict_percolation(input cell_t c);
		perc_t o;
		logic [63:0] bottom, keff, top, dl, sat, lam, ex, flux, stored, cap, rise;
		bottom = 64'(sh_two_layer ? c.depth_bottom_layer : c.depth_top_layer);
		o.cell_index_out = c.cell_index;
		o.percolation = '0;
		o.moisture_new = c.moisture_now;
		o.wetting_front_new = c.wetting_front;
		o.updated = 1'b0;
		if (!(sh_gw_flow && (64'(c.gw_height) + 64'(sh_gw_margin) > bottom)) &&
				c.moisture_now > c.residual_moisture) begin
			o.updated = 1'b1;
			keff = (64'(sh_ksat_factor) * 64'(c.ksat)) >> 24;
			if (keff > 64'hFFFF_FFFF) keff = 64'hFFFF_FFFF;
			if (64'(c.wetting_front) + 64'd16777 < bottom) begin
				top = 64'(c.wetting_front);
				if (sh_two_layer && c.depth_top_layer > c.wetting_front)
					top = 64'(c.depth_top_layer);
				dl = (bottom > top) ? bottom - top : 64'd0;
				if (dl != 0) begin
					if (c.porosity > c.residual_moisture) begin
						sat = (64'(c.moisture_now - c.residual_moisture) << 24) /
							64'(c.porosity - c.residual_moisture);
						if (sat > ONE) sat = ONE;
					end else begin
						sat = ONE;
					end
					lam = (c.pore_index == 0) ? 64'd1 : 64'(c.pore_index);
					ex = 3 * ONE + ((64'd2 << 48) / lam);
					flux = (keff * sat_power_q32(sat, ex)) >> 32;
					stored = dl * 64'(c.moisture_now - c.residual_moisture);
					cap = stored >> 24;
					o.percolation = 32'((flux < cap) ? flux : cap);
					o.moisture_new = 25'(64'(c.residual_moisture) +
						(stored - (64'(o.percolation) << 24)) / dl);
				end
			end else begin
				o.moisture_new = c.field_capacity;
				o.percolation = 32'(keff);
				if (keff != 0) begin
					if (c.porosity > c.field_capacity) begin
						rise = (keff << 24) / 64'(c.porosity - c.field_capacity);
						o.wetting_front_new = (rise >= 64'(c.wetting_front)) ? 32'd0 :
							32'(64'(c.wetting_front) - rise);
					end else begin
						o.wetting_front_new = '0;
					end
				end
			end
		end
		return o;
	endfunction

	// Checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		perc_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.cell_index_out = m_axis_tdata[23:0];
			got.percolation = m_axis_tdata[55:24];
			got.moisture_new = m_axis_tdata[80:56];
			got.wetting_front_new = m_axis_tdata[112:81];
			got.updated = m_axis_tdata[113];
			if (pending_perc.size() == 0) begin
				$error("unexpected result, cell_index_out %0d", got.cell_index_out);
				errors++;
			end else begin
				want = pending_perc.pop_front();
				if (got.cell_index_out !== want.cell_index_out) begin
					$error("cell_index_out expected %0d actual %0d", want.cell_index_out,
						got.cell_index_out);
					errors++;
				end
				if (got.percolation !== want.percolation) begin
					$error("percolation expected %0d actual %0d", want.percolation, got.percolation);
					errors++;
				end
				if (got.moisture_new !== want.moisture_new) begin
					$error("moisture_new expected %0d actual %0d", want.moisture_new,
						got.moisture_new);
					errors++;
				end
				if (got.wetting_front_new !== want.wetting_front_new) begin
					$error("wetting_front_new expected %0d actual %0d", want.wetting_front_new,
						got.wetting_front_new);
					errors++;
				end
				if (got.updated !== want.updated) begin
					$error("updated expected %0d actual %0d", want.updated, got.updated);
					errors++;
				end
			end
		end
	end

	// Receiver: random stalls, ready stretches, and long hold-offs on request.
	always @(posedge clk) begin
		stall_phase <= (stall_phase + 1) % 400;
		if (hold_cnt > 0) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_cnt <= 600;
			m_axis_tready <= 1'b0;
		end else if (stall_phase < 120) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("soil_bottom_percolation regression: fail");
			$finish;
		end
	end

	task automatic send_cell(input cell_t c);
		if (burst_left == 0) begin
			int gap;
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, c.gw_height, c.pore_index, c.ksat, c.field_capacity,
			c.moisture_now, c.residual_moisture, c.porosity, c.depth_bottom_layer,
			c.depth_top_layer, c.wetting_front, c.cell_index};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_perc.push_back(predict_percolation(c));
	endtask

	// Waits for every expected result, then for the pipeline to empty.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_perc.size() != 0) @(posedge clk);
		repeat (LATENCY + 12) @(posedge clk);
	endtask

	task automatic write_reg(input sbp_pkg::cfg_idx_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			sbp_pkg::CFG_TWO_LAYER: sh_two_layer = value[0];
			sbp_pkg::CFG_GW_FLOW: sh_gw_flow = value[0];
			sbp_pkg::CFG_GW_MARGIN: sh_gw_margin = value;
			sbp_pkg::CFG_KSAT_FACTOR: sh_ksat_factor = value;
			default: ;
		endcase
	endtask

	function automatic cell_t random_cell();
		cell_t c;
		logic [31:0] bottom;
		c.cell_index = 24'($urandom);
		if ($urandom_range(0, 9) < 2) begin
			c.wetting_front = $urandom;
			c.depth_top_layer = $urandom;
			c.depth_bottom_layer = $urandom;
			c.porosity = 25'($urandom_range(0, 1 << 24));
			c.residual_moisture = 25'($urandom_range(0, 1 << 24));
			c.moisture_now = 25'($urandom_range(0, 1 << 24));
			c.field_capacity = 25'($urandom_range(0, 1 << 24));
			c.ksat = $urandom;
			c.pore_index = $urandom_range(1, 32'hFFFF_FFFF);
			c.gw_height = $urandom;
		end else begin
			c.depth_top_layer = $urandom_range(0, 3 << 24);
			c.depth_bottom_layer = c.depth_top_layer + $urandom_range(0, 3 << 24);
			bottom = sh_two_layer ? c.depth_bottom_layer : c.depth_top_layer;
			case ($urandom_range(0, 3))
				0: c.wetting_front = (bottom > 40000) ? bottom - $urandom_range(0, 40000) : 0;
				1: c.wetting_front = $urandom_range(0, 8 << 24);
				default: c.wetting_front = $urandom_range(0, bottom);
			endcase
			c.porosity = 25'($urandom_range(1 << 22, 1 << 24));
			c.residual_moisture = 25'($urandom_range(0, c.porosity / 2));
			c.moisture_now = 25'($urandom_range(c.residual_moisture, c.porosity));
			c.field_capacity = 25'($urandom_range(c.residual_moisture, c.porosity));
			c.ksat = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 24);
			c.pore_index = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1 << 22) :
				$urandom_range(1 << 22, 4 << 24);
			c.gw_height = $urandom_range(0, 6 << 24);
		end
		return c;
	endfunction

	function automatic cell_t typical_cell(input logic [23:0] idx);
		cell_t c;
		c.cell_index = idx;
		c.wetting_front = 32'd8388608;
		c.depth_top_layer = 32'd16777216;
		c.depth_bottom_layer = 32'd33554432;
		c.porosity = 25'd7549747;
		c.residual_moisture = 25'd838861;
		c.moisture_now = 25'd5033165;
		c.field_capacity = 25'd4194304;
		c.ksat = 32'd167772;
		c.pore_index = 32'd5033165;
		c.gw_height = 32'd0;
		return c;
	endfunction

	task automatic test_directed;
		cell_t c;
		for (int pass = 0; pass < 2; pass++) begin
			write_reg(sbp_pkg::CFG_TWO_LAYER, 32'(pass));
			write_reg(sbp_pkg::CFG_GW_FLOW, 32'd1);
			write_reg(sbp_pkg::CFG_GW_MARGIN, 32'd1 << 23);
			c = typical_cell(24'd1); send_cell(c);
			c.gw_height = 32'd40 << 24; send_cell(c);                // high groundwater
			c = typical_cell(24'd2); c.moisture_now = c.residual_moisture; send_cell(c);
			c = typical_cell(24'd3); c.wetting_front = 32'd16777216 - 100; send_cell(c);
			c.depth_bottom_layer = c.wetting_front; send_cell(c);     // front at bottom
			c.field_capacity = 25'd8000000; send_cell(c);             // fc above porosity
			c = typical_cell(24'd4); c.moisture_now = 25'd9000000; send_cell(c);
			c = typical_cell(24'd5); c.porosity = 25'd500000; send_cell(c);
			c = typical_cell(24'd6); c.pore_index = 32'd1; send_cell(c);  // huge exponent
			c = typical_cell(24'd7); c.wetting_front = 0; c.depth_top_layer = 32'd50 << 24;
			send_cell(c);                                              // layer 1 below layer 2
			c = typical_cell(24'hFFFFFF); c.ksat = 32'hFFFF_FFFF; c.pore_index = 32'hFFFF_FFFF;
			c.depth_bottom_layer = 32'hFFFF_FFFF; c.depth_top_layer = 32'hFFFF_FFF0;
			c.porosity = 25'd16777216; c.moisture_now = 25'd16777216;
			c.field_capacity = 25'd16777216; c.gw_height = 32'hFFFF_FFFF; send_cell(c);
			c.gw_height = 0; send_cell(c);
			c = typical_cell(24'd0); c.wetting_front = 32'hFFFF_FFFF; c.residual_moisture = 0;
			c.moisture_now = 25'd1; send_cell(c);
			drain;
		end
		write_reg(sbp_pkg::CFG_KSAT_FACTOR, 32'd0);
		c = typical_cell(24'd8); send_cell(c);
		c.wetting_front = 32'd40 << 24; send_cell(c);             // zero effective ksat
		drain;
		write_reg(sbp_pkg::CFG_KSAT_FACTOR, 32'hFFFF_FFFF);
		write_reg(sbp_pkg::CFG_GW_MARGIN, 32'hFFFF_FFFF);
		c = typical_cell(24'd9); send_cell(c);
		drain;
		write_reg(sbp_pkg::CFG_GW_FLOW, 32'd0);
		c.ksat = 32'hFFFF_FFFF; send_cell(c);
		c.wetting_front = 32'd40 << 24; send_cell(c);
		drain;
	endtask

	task automatic test_random;
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(sbp_pkg::CFG_TWO_LAYER, $urandom_range(0, 1));
			write_reg(sbp_pkg::CFG_GW_FLOW, $urandom_range(0, 1));
			write_reg(sbp_pkg::CFG_GW_MARGIN, (phase == 7) ? 32'hFFFF_FFFF :
				(phase == 0) ? 32'd0 : $urandom_range(0, 2 << 24));
			write_reg(sbp_pkg::CFG_KSAT_FACTOR, (phase == 1) ? 32'hFFFF_FFFF :
				(phase == 2) ? 32'd0 : $urandom_range(1 << 22, 4 << 24));
			repeat (125) send_cell(random_cell());
			drain;
		end
	endtask

	task automatic test_backpressure;
		write_reg(sbp_pkg::CFG_TWO_LAYER, 32'd1);
		write_reg(sbp_pkg::CFG_KSAT_FACTOR, sbp_pkg::KSAT_ONE);
		hold_seq++;
		// The sender keeps offering items while the receiver holds off.
		burst_left = 200;
		repeat (150) send_cell(random_cell());
		drain;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed;
		test_random;
		test_backpressure;
		if (errors == 0) begin
			$display("soil_bottom_percolation regression: pass");
		end else begin
			$display("soil_bottom_percolation regression: fail");
		end
		$finish;
	end

endmodule
